// ===== rtl/tbsr_pkg.sv =====
`default_nettype none

package tbsr_pkg;

  localparam int unsigned MAX_DIM       = 8192;
  localparam int unsigned MAX_TILE_LOG2 = 8;

  localparam int unsigned COORD_W = 13;
  localparam int unsigned BLK_W   = COORD_W - 2;
  localparam int unsigned DIM_W   = 14;
  localparam int unsigned INDEX_W = 26;
  localparam int unsigned LOC_W   = MAX_TILE_LOG2;
  localparam int unsigned K_W     = 4;

  localparam logic [DIM_W-1:0] MAX_DIM_C       = DIM_W'(MAX_DIM);
  localparam logic [K_W-1:0]   MAX_TILE_LOG2_C = K_W'(MAX_TILE_LOG2);

  localparam logic [2:0] CFG_SWZ_SEL      = 3'd0;
  localparam logic [2:0] CFG_CLR_SEL      = 3'd1;
  localparam logic [2:0] CFG_TILE_LOG2    = 3'd2;
  localparam logic [2:0] CFG_IMAGE_WIDTH  = 3'd3;
  localparam logic [2:0] CFG_IMAGE_HEIGHT = 3'd4;

  localparam logic [1:0] SWZ_MORTON    = 2'd0;
  localparam logic [1:0] SWZ_TRANSPOSE = 2'd1;
  localparam logic [1:0] SWZ_COLMAJOR  = 2'd2;
  localparam logic [1:0] SWZ_SCRAMBLE  = 2'd3;

  localparam logic [2:0] CLR_NONE   = 3'd0;
  localparam logic [2:0] CLR_SWAP   = 3'd1;
  localparam logic [2:0] CLR_XOR    = 3'd2;
  localparam logic [2:0] CLR_TINT   = 3'd3;
  localparam logic [2:0] CLR_ROTATE = 3'd4;
  localparam logic [2:0] CLR_CRUSH  = 3'd5;
  localparam logic [2:0] CLR_GRAY   = 3'd6;
  localparam logic [2:0] CLR_INVERT = 3'd7;

  localparam logic [7:0]  XOR_MUL_R  = 8'd17;
  localparam logic [7:0]  XOR_MUL_G  = 8'd29;
  localparam logic [7:0]  XOR_MUL_B  = 8'd13;
  localparam logic [7:0]  CRUSH_MASK = 8'hF0;
  localparam logic [7:0]  FULL_8     = 8'hFF;
  localparam logic [15:0] LUMA_R     = 16'd77;
  localparam logic [15:0] LUMA_G     = 16'd150;
  localparam logic [15:0] LUMA_B     = 16'd29;
  localparam int unsigned TINT_MUL_R = 3;
  localparam int unsigned TINT_MUL_G = 5;
  localparam int unsigned TINT_MUL_B = 7;

  localparam logic [2:0]  RST_SWIZZLE = SWZ_MORTON;
  localparam logic [2:0]  RST_COLOR   = CLR_NONE;
  localparam logic [K_W-1:0]   RST_TILE_LOG2 = K_W'(4);
  localparam logic [DIM_W-1:0] RST_WIDTH     = DIM_W'(1024);
  localparam logic [DIM_W-1:0] RST_HEIGHT    = DIM_W'(1024);

  typedef struct packed {
    logic [COORD_W-1:0] src_x;
    logic [COORD_W-1:0] src_y;
    logic [7:0]         red_in;
    logic [7:0]         green_in;
    logic [7:0]         blue_in;
    logic [7:0]         alpha_in;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [INDEX_W-1:0] dst_index;
    logic               write_enable;
    logic [7:0]         red_out;
    logic [7:0]         green_out;
    logic [7:0]         blue_out;
    logic [7:0]         alpha_out;
  } out_t;

  typedef struct packed {
    logic [1:0]       swz_sel;
    logic [2:0]       clr_sel;
    logic [K_W-1:0]   tile_log2;
    logic [DIM_W-1:0] image_width;
    logic [DIM_W-1:0] image_height;
  } cfg_t;

  typedef struct packed {
    logic [COORD_W-1:0] dst_x;
    logic [COORD_W-1:0] dst_y;
    logic [INDEX_W-1:0] dst_index;
    logic               write_enable;
  } geo_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] alpha;
  } pix_t;

endpackage

`default_nettype wire

// ===== rtl/texture_block_swizzle_recolor_core.sv =====
// An accepted request is registered in the input register, and its result then in the output register.
// Throughput: one request per cycle; the input register and the output register
// form a two-stage pipeline that advances whenever the output side is not stalled.
// Reset (synchronous, rst_n low) empties both stages and loads the register
// defaults: Morton swizzle, no recolor, 16-block macrotiles, 1024 x 1024 image.
`default_nettype none

module texture_block_swizzle_recolor_core (
  input  wire logic                         clk,
  input  wire logic                         rst_n,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire tbsr_pkg::in_t                in_data,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output tbsr_pkg::out_t                    out_data,
  input  wire logic                         cfg_we,
  input  wire logic [2:0]                   cfg_addr,
  input  wire logic [tbsr_pkg::DIM_W-1:0]   cfg_wdata
);

  tbsr_pkg::cfg_t cfg_r;
  tbsr_pkg::in_t  s0_data_r;
  logic           s0_valid_r;
  tbsr_pkg::out_t out_data_r;
  logic           out_valid_r;
  tbsr_pkg::geo_t geo;
  tbsr_pkg::pix_t pix;
  tbsr_pkg::out_t out_nxt;
  logic           adv_out;
  logic           adv_s0;

  assign adv_out  = !out_valid_r || !out_stall;
  assign adv_s0   = !s0_valid_r || adv_out;
  assign in_stall = !adv_s0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.swz_sel      <= tbsr_pkg::RST_SWIZZLE[1:0];
      cfg_r.clr_sel      <= tbsr_pkg::RST_COLOR;
      cfg_r.tile_log2    <= tbsr_pkg::RST_TILE_LOG2;
      cfg_r.image_width  <= tbsr_pkg::RST_WIDTH;
      cfg_r.image_height <= tbsr_pkg::RST_HEIGHT;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        tbsr_pkg::CFG_SWZ_SEL:      cfg_r.swz_sel      <= cfg_wdata[1:0];
        tbsr_pkg::CFG_CLR_SEL:      cfg_r.clr_sel      <= cfg_wdata[2:0];
        tbsr_pkg::CFG_TILE_LOG2:    cfg_r.tile_log2    <= cfg_wdata[tbsr_pkg::K_W-1:0];
        tbsr_pkg::CFG_IMAGE_WIDTH:  cfg_r.image_width  <= cfg_wdata;
        tbsr_pkg::CFG_IMAGE_HEIGHT: cfg_r.image_height <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (adv_s0) begin
        s0_valid_r <= in_valid;
      end
      if (adv_out) begin
        out_valid_r <= s0_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv_s0 && in_valid) begin
      s0_data_r <= in_data;
    end
    if (adv_out && s0_valid_r) begin
      out_data_r <= out_nxt;
    end
  end

  tbsr_swizzle u_swizzle (
    .cfg    (cfg_r),
    .pix_in (s0_data_r),
    .geo    (geo)
  );

  tbsr_recolor u_recolor (
    .clr_sel (cfg_r.clr_sel),
    .pix_in  (s0_data_r),
    .pix_out (pix)
  );

  always_comb begin
    out_nxt.dst_x        = geo.dst_x;
    out_nxt.dst_y        = geo.dst_y;
    out_nxt.dst_index    = geo.dst_index;
    out_nxt.write_enable = geo.write_enable;
    out_nxt.red_out      = pix.red;
    out_nxt.green_out    = pix.green;
    out_nxt.blue_out     = pix.blue;
    out_nxt.alpha_out    = pix.alpha;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // An accepted request always lands in the input stage.
  a_accept_fills_s0: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> s0_valid_r)
    else $error("accepted request did not reach the input stage");

  // A result held by a stall is not dropped.
  a_stall_holds_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("stalled result was dropped");

  // A result without a write carries a zero destination.
  a_no_write_zero_dst: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.write_enable |->
      out_data.dst_x == '0 && out_data.dst_y == '0 && out_data.dst_index == '0)
    else $error("destination not cleared on a result without a write");

  // The input stage is never stalled while the output side can move.
  a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s0_valid_r && out_valid_r && out_stall)
    else $error("input stalled with room in the pipeline");

endmodule

`default_nettype wire

// ===== rtl/tbsr_swizzle.sv =====
`default_nettype none

module tbsr_swizzle (
  input  wire tbsr_pkg::cfg_t  cfg,
  input  wire tbsr_pkg::in_t   pix_in,
  output tbsr_pkg::geo_t       geo
);

  localparam int unsigned LW  = tbsr_pkg::LOC_W;
  localparam int unsigned BW  = tbsr_pkg::BLK_W;
  localparam int unsigned CW  = tbsr_pkg::COORD_W;
  localparam int unsigned DW  = tbsr_pkg::DIM_W;
  localparam int unsigned IW  = tbsr_pkg::INDEX_W;
  localparam int unsigned KW  = tbsr_pkg::K_W;
  localparam int unsigned PW  = CW + DW;

  logic [KW-1:0]   k;
  logic [LW-1:0]   tmask;
  logic [BW-1:0]   bx;
  logic [BW-1:0]   by;
  logic [LW-1:0]   lx;
  logic [LW-1:0]   ly;
  logic [2*LW-1:0] morton;
  logic [LW-1:0]   rev_x;
  logic [LW-1:0]   rev_y;
  logic [LW-1:0]   nx;
  logic [LW-1:0]   ny;
  logic [BW-1:0]   dbx;
  logic [BW-1:0]   dby;
  logic [DW-1:0]   w_sat;
  logic [DW-1:0]   h_sat;
  logic [DW-3:0]   w_blk;
  logic [DW-3:0]   h_blk;
  logic            we;
  logic [CW-1:0]   dx;
  logic [CW-1:0]   dy;
  logic [PW-1:0]   prod;

  always_comb begin
    if (cfg.tile_log2 == '0) begin
      k = KW'(1);
    end else if (cfg.tile_log2 > tbsr_pkg::MAX_TILE_LOG2_C) begin
      k = tbsr_pkg::MAX_TILE_LOG2_C;
    end else begin
      k = cfg.tile_log2;
    end
  end

  assign tmask = LW'(((LW+1)'(1) << k) - (LW+1)'(1));
  assign bx    = pix_in.src_x[CW-1:2];
  assign by    = pix_in.src_y[CW-1:2];
  assign lx    = bx[LW-1:0] & tmask;
  assign ly    = by[LW-1:0] & tmask;

  always_comb begin
    for (int i = 0; i < LW; i++) begin
      morton[2*i]     = lx[i];
      morton[2*i + 1] = ly[i];
      rev_x[LW-1-i]   = lx[i];
      rev_y[LW-1-i]   = ly[i];
    end
  end

  always_comb begin
    case (cfg.swz_sel)
      tbsr_pkg::SWZ_MORTON: begin
        nx = morton[LW-1:0] & tmask;
        ny = LW'(morton >> k);
      end
      tbsr_pkg::SWZ_SCRAMBLE: begin
        nx = rev_x >> (KW'(LW) - k);
        ny = rev_y >> (KW'(LW) - k);
      end
      default: begin
        nx = ly;
        ny = lx;
      end
    endcase
  end

  assign dbx   = (bx & ~BW'(tmask)) | BW'(nx);
  assign dby   = (by & ~BW'(tmask)) | BW'(ny);
  assign w_sat = (cfg.image_width > tbsr_pkg::MAX_DIM_C) ? tbsr_pkg::MAX_DIM_C
                                                         : cfg.image_width;
  assign h_sat = (cfg.image_height > tbsr_pkg::MAX_DIM_C) ? tbsr_pkg::MAX_DIM_C
                                                          : cfg.image_height;
  assign w_blk = w_sat[DW-1:2];
  assign h_blk = h_sat[DW-1:2];

  assign we = ((DW-2)'(bx) < w_blk) && ((DW-2)'(by) < h_blk) &&
              ((DW-2)'(dbx) < w_blk) && ((DW-2)'(dby) < h_blk);

  assign dx   = {dbx, pix_in.src_x[1:0]};
  assign dy   = {dby, pix_in.src_y[1:0]};
  assign prod = PW'(dy) * PW'(w_sat) + PW'(dx);

  always_comb begin
    if (we) begin
      geo.dst_x     = dx;
      geo.dst_y     = dy;
      geo.dst_index = prod[IW-1:0];
    end else begin
      geo.dst_x     = '0;
      geo.dst_y     = '0;
      geo.dst_index = '0;
    end
    geo.write_enable = we;
  end

endmodule

`default_nettype wire

// ===== rtl/tbsr_recolor.sv =====
`default_nettype none

module tbsr_recolor (
  input  wire logic [2:0]    clr_sel,
  input  wire tbsr_pkg::in_t pix_in,
  output tbsr_pkg::pix_t     pix_out
);

  localparam int unsigned BW = tbsr_pkg::BLK_W;
  localparam int unsigned CW = tbsr_pkg::COORD_W;

  logic [BW-1:0] bx;
  logic [BW-1:0] by;
  logic [7:0]    r;
  logic [7:0]    g;
  logic [7:0]    b;
  logic [7:0]    a;
  logic [BW:0]   bsum;
  logic [4:0]    fold1;
  logic [2:0]    fold2;
  logic [1:0]    q;
  logic [14:0]   tint_r;
  logic [14:0]   tint_g;
  logic [14:0]   tint_b;
  logic [15:0]   luma;

  assign bx = pix_in.src_x[CW-1:2];
  assign by = pix_in.src_y[CW-1:2];
  assign r  = pix_in.red_in;
  assign g  = pix_in.green_in;
  assign b  = pix_in.blue_in;
  assign a  = pix_in.alpha_in;

  // Residue mod 3: even bit positions weigh 1, odd ones weigh 2.
  assign bsum = (BW+1)'(bx) + (BW+1)'(by);

  always_comb begin
    fold1 = '0;
    for (int i = 0; i <= BW; i++) begin
      fold1 = fold1 + ((i % 2 == 0) ? 5'(bsum[i]) : 5'({bsum[i], 1'b0}));
    end
    fold2 = 3'(fold1[0]) + 3'(fold1[2]) + 3'(fold1[4]) +
            3'({fold1[1], 1'b0}) + 3'({fold1[3], 1'b0});
    if (fold2 >= 3'd6) begin
      q = 2'(fold2 - 3'd6);
    end else if (fold2 >= 3'd3) begin
      q = 2'(fold2 - 3'd3);
    end else begin
      q = fold2[1:0];
    end
  end

  assign tint_r = 15'(r) + 15'(bx) * 15'(tbsr_pkg::TINT_MUL_R);
  assign tint_g = 15'(g) + 15'(by) * 15'(tbsr_pkg::TINT_MUL_G);
  assign tint_b = 15'(b) + 15'(bx ^ by) * 15'(tbsr_pkg::TINT_MUL_B);
  assign luma   = 16'(r) * tbsr_pkg::LUMA_R + 16'(g) * tbsr_pkg::LUMA_G +
                  16'(b) * tbsr_pkg::LUMA_B;

  always_comb begin
    pix_out.red   = r;
    pix_out.green = g;
    pix_out.blue  = b;
    pix_out.alpha = a;
    case (clr_sel)
      tbsr_pkg::CLR_SWAP: begin
        pix_out.red   = b;
        pix_out.green = r;
        pix_out.blue  = g;
      end
      tbsr_pkg::CLR_XOR: begin
        pix_out.red   = r ^ 8'(bx[7:0] * tbsr_pkg::XOR_MUL_R);
        pix_out.green = g ^ 8'(by[7:0] * tbsr_pkg::XOR_MUL_G);
        pix_out.blue  = b ^ 8'((bx[7:0] + by[7:0]) * tbsr_pkg::XOR_MUL_B);
      end
      tbsr_pkg::CLR_TINT: begin
        pix_out.red   = (tint_r > 15'(tbsr_pkg::FULL_8)) ? tbsr_pkg::FULL_8 : tint_r[7:0];
        pix_out.green = (tint_g > 15'(tbsr_pkg::FULL_8)) ? tbsr_pkg::FULL_8 : tint_g[7:0];
        pix_out.blue  = (tint_b > 15'(tbsr_pkg::FULL_8)) ? tbsr_pkg::FULL_8 : tint_b[7:0];
      end
      tbsr_pkg::CLR_ROTATE: begin
        if (q == 2'd1) begin
          pix_out.red   = g;
          pix_out.green = b;
          pix_out.blue  = r;
        end else if (q == 2'd2) begin
          pix_out.red   = b;
          pix_out.green = r;
          pix_out.blue  = g;
        end
      end
      tbsr_pkg::CLR_CRUSH: begin
        pix_out.red   = r & tbsr_pkg::CRUSH_MASK;
        pix_out.green = g & tbsr_pkg::CRUSH_MASK;
        pix_out.blue  = b & tbsr_pkg::CRUSH_MASK;
      end
      tbsr_pkg::CLR_GRAY: begin
        pix_out.red   = luma[15:8];
        pix_out.green = luma[15:8];
        pix_out.blue  = luma[15:8];
        pix_out.alpha = tbsr_pkg::FULL_8;
      end
      tbsr_pkg::CLR_INVERT: begin
        pix_out.red   = ~r;
        pix_out.green = ~g;
        pix_out.blue  = ~b;
      end
      default: begin
        pix_out.alpha = a;
      end
    endcase
  end

endmodule

`default_nettype wire
